// ----- rtl/srd_pkg.sv -----
// ---------------------------------------------------------------------------
// srd_pkg: shared types and constants of the decimated reverberator
// Sequencer states, register indexes, line base lengths and Q1.15 gains.
// ---------------------------------------------------------------------------
package srd_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,   // zero the line memory after reset
      ST_IDLE,    // wait for an input beat
      ST_C_RD,    // comb: issue line read
      ST_C_MUL,   // comb: read data back, feedback product
      ST_C_WR,    // comb: write back, advance pointer
      ST_A_RD,    // allpass: issue read, feed-forward product
      ST_A_SUB,   // allpass: tap value
      ST_A_MUL,   // allpass: feedback product
      ST_A_WR,    // allpass: write back, advance pointer
      ST_MIX,     // wet/dry sum
      ST_DIV,     // divide by 100
      ST_OUT      // load output register
   } state_type;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_PCT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_PCT   = 1'd1;

   localparam int unsigned PCT_W = 7;
   localparam logic [PCT_W-1:0] PCT_MAX       = 7'd100;
   localparam logic [PCT_W-1:0] DELAY_PCT_RST = 7'd100;
   localparam logic [PCT_W-1:0] WET_PCT_RST   = 7'd50;

   // four combs then three allpasses
   localparam int unsigned NUM_LINES  = 7;
   localparam int unsigned NUM_COMBS  = 4;
   localparam int unsigned LINE_IDX_W = 3;
   localparam logic [LINE_IDX_W-1:0] LAST_COMB = 3'd3;
   localparam logic [LINE_IDX_W-1:0] FIRST_AP  = 3'd4;
   localparam logic [LINE_IDX_W-1:0] LAST_AP   = 3'd6;

   // undecimated base lengths, divided by the decimation factor at the top
   localparam int unsigned BASE_RAW [NUM_LINES] = '{3460, 2988, 3882, 4312, 480, 161, 46};

   // Q1.15 gains
   localparam int unsigned GAIN_W = 16;
   localparam logic signed [GAIN_W-1:0] COMB_GAIN [NUM_COMBS] =
      '{16'sd26378, 16'sd27099, 16'sd25657, 16'sd25035};
   localparam logic signed [GAIN_W-1:0] AP_GAIN = 16'sd22938;

endpackage

// ----- rtl/srd_ram.sv -----
// ---------------------------------------------------------------------------
// srd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module srd_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/schroeder_reverb_decimated.sv -----
// ---------------------------------------------------------------------------
// schroeder_reverb_decimated: decimated Schroeder reverberator
// Four parallel feedback combs, averaged, into three series allpasses, run
// once every DECIMATION samples; the wet result is held and mixed with each
// dry sample. All seven delay lines share one RAM.
// ---------------------------------------------------------------------------
//
//  channel  | ports                                  | beat moves
//  ---------+----------------------------------------+---------------------
//  req      | req_valid, req_ready, req_sample_in    | one dry sample
//  rsp      | rsp_valid, rsp_ready, rsp_sample_out   | one mixed sample
//  csr      | csr_we, csr_index, csr_wdata           | one register write
//
//  Steps: a plain beat runs accept, mix, divide and output. A beat that
//  fires the reverb core also runs read, multiply and write-back for each
//  comb and read, subtract, multiply and write-back for each allpass, on the
//  single line RAM port pair and the shared multiplier.
//  Reset: a clearing pass zeroes the line RAM, one entry a cycle, over every
//  entry of all seven lines; req_ready is low meanwhile, csr writes are taken.
//  A new req beat is taken while a result still waits in the output register;
//  only the output step stalls on it.
// ---------------------------------------------------------------------------
module schroeder_reverb_decimated #(
   parameter int unsigned DECIMATION   = 5,
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out,
   input  logic                                csr_we,
   input  logic [srd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srd_pkg::PCT_W-1:0]           csr_wdata
);

   import srd_pkg::*;

   localparam int unsigned SW = SAMPLE_WIDTH;

   // line lengths and their places in the shared RAM
   localparam int unsigned LB0 = BASE_RAW[0] / DECIMATION;
   localparam int unsigned LB1 = BASE_RAW[1] / DECIMATION;
   localparam int unsigned LB2 = BASE_RAW[2] / DECIMATION;
   localparam int unsigned LB3 = BASE_RAW[3] / DECIMATION;
   localparam int unsigned LB4 = BASE_RAW[4] / DECIMATION;
   localparam int unsigned LB5 = BASE_RAW[5] / DECIMATION;
   localparam int unsigned LB6 = BASE_RAW[6] / DECIMATION;
   localparam int unsigned LINE_BASE [NUM_LINES] = '{LB0, LB1, LB2, LB3, LB4, LB5, LB6};
   localparam int unsigned OF1 = LB0 + 1;
   localparam int unsigned OF2 = OF1 + LB1 + 1;
   localparam int unsigned OF3 = OF2 + LB2 + 1;
   localparam int unsigned OF4 = OF3 + LB3 + 1;
   localparam int unsigned OF5 = OF4 + LB4 + 1;
   localparam int unsigned OF6 = OF5 + LB5 + 1;
   localparam int unsigned LINE_OFFS [NUM_LINES] = '{0, OF1, OF2, OF3, OF4, OF5, OF6};
   localparam int unsigned MEM_DEPTH = OF6 + LB6 + 1;
   localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
   localparam int unsigned PTR_W     = $clog2(LB3 + 2);  // comb3 is the longest
   localparam int unsigned LIM_W     = PTR_W + PCT_W;
   localparam int unsigned DCNT_W    = $clog2(DECIMATION + 1);

   // arithmetic widths
   localparam int unsigned PROD_W = SW + GAIN_W;
   localparam int unsigned EXT_W  = SW + 3;
   localparam int unsigned MIX_W  = SW + 9;
   localparam int unsigned U_W    = SW + 7;          // biased mix, unsigned
   localparam int unsigned M_W    = U_W + 1;
   localparam int unsigned RSH    = U_W + 7;
   localparam int unsigned Q_W    = SW + 1;
   localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << RSH) + 64'd99) / 64'd100);

   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((1 << (SW - 1)) - 1);
   localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [EXT_W-1:0] TWO    = EXT_W'(2);
   localparam logic signed [EXT_W-1:0] HALF   = EXT_W'(1 << (SW - 1));
   localparam logic signed [PROD_W-1:0] RND15 = PROD_W'(1 << 14);
   localparam logic signed [MIX_W-1:0] HUNDRED = MIX_W'(100);
   localparam logic signed [MIX_W-1:0] MIX_OFS = MIX_W'(50 + 100 * (1 << (SW - 1)));

   function automatic logic signed [SW-1:0] sat(input logic signed [EXT_W-1:0] v);
      logic signed [SW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SW-1:0];
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   // Q1.15 product rounded half up, floor
   function automatic logic signed [SW:0] rnd15(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + RND15;
      return t[PROD_W-1:15];
   endfunction

   function automatic logic [PCT_W-1:0] clip_pct(input logic [PCT_W-1:0] v);
      return (v > PCT_MAX) ? PCT_MAX : v;
   endfunction

   // ---------------- registers ----------------
   state_type                 state_ff,     state_in;
   logic [ADDR_W-1:0]         clr_ff,       clr_in;
   logic [LINE_IDX_W-1:0]     li_ff,        li_in;
   logic [DCNT_W-1:0]         dcnt_ff,      dcnt_in;
   logic [PTR_W-1:0]          ptr_ff [NUM_LINES];
   logic [PTR_W-1:0]          ptr_in [NUM_LINES];
   logic [PCT_W-1:0]          delay_pct_ff, delay_pct_in;
   logic [PCT_W-1:0]          wet_pct_ff,   wet_pct_in;
   logic signed [SW-1:0]      held_ff,      held_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [SW-1:0]      x_ff,         x_in;
   logic signed [PROD_W-1:0]  prod_ff,      prod_in;
   logic signed [SW-1:0]      rb_ff,        rb_in;
   logic signed [SW+1:0]      sum_ff,       sum_in;
   logic signed [SW-1:0]      ap_in_ff,     ap_in_in;
   logic [LIM_W-1:0]          lim_ff,       lim_in;
   logic [PTR_W-1:0]          eptr_ff,      eptr_in;
   logic [U_W-1:0]            mix_ff,       mix_in;
   logic [Q_W-1:0]            q_ff,         q_in;
   logic signed [SW-1:0]      out_ff,       out_in;

   // ---------------- datapath wires ----------------
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [ADDR_W-1:0]         mem_raddr;
   logic [SW-1:0]             mem_wdata;
   logic [SW-1:0]             mem_rdata;
   logic signed [SW-1:0]      rdata_s;

   logic [PTR_W-1:0]          base_sel;
   logic [PTR_W-1:0]          ptr_sel;
   logic [PTR_W-1:0]          eptr;
   logic [PTR_W-1:0]          ptr_nxt;
   logic                      ptr_wrap;
   logic signed [SW-1:0]      mul_a;
   logic signed [GAIN_W-1:0]  mul_g;
   logic signed [EXT_W-1:0]   avg_t;
   logic signed [SW:0]        wet_diff;
   logic signed [MIX_W-1:0]   mix_t;
   logic [U_W+M_W-1:0]        recip_p;
   logic signed [EXT_W-1:0]   out_t;
   logic [DCNT_W-1:0]         dcnt_nxt;
   logic                      trig;

   srd_ram #(
      .WIDTH (SW),
      .DEPTH (MEM_DEPTH)
   ) u_lines (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rdata_s   = $signed(mem_rdata);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

   // current line: base, pointer (out-of-range pointer acts as zero)
   assign base_sel = PTR_W'(LINE_BASE[li_ff]);
   assign ptr_sel  = ptr_ff[li_ff];
   assign eptr     = (ptr_sel > base_sel) ? '0 : ptr_sel;
   assign mem_raddr = ADDR_W'(LINE_OFFS[li_ff]) + ADDR_W'(eptr);

   // pointer advance: wrap once 100*ptr exceeds percent*base, i.e. ptr > length
   assign ptr_nxt  = eptr_ff + PTR_W'(1);
   assign ptr_wrap = (LIM_W'(ptr_nxt) * LIM_W'(PCT_MAX)) > lim_ff;

   // shared Q1.15 multiplier
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_g);

   assign avg_t    = (EXT_W'(sum_ff) + TWO) >>> 2;
   assign wet_diff = (SW + 1)'(held_ff) - (SW + 1)'(x_ff);
   assign mix_t    = MIX_W'($signed({1'b0, clip_pct(wet_pct_ff)})) * MIX_W'(wet_diff)
                   + MIX_W'(x_ff) * HUNDRED + MIX_OFS;
   // floor(u/100) by reciprocal, exact for every U_W-bit u
   assign recip_p  = (U_W + M_W)'(mix_ff) * (U_W + M_W)'(RECIP);
   assign out_t    = EXT_W'($signed({2'b00, q_ff})) - HALF;

   assign dcnt_nxt = dcnt_ff + DCNT_W'(1);
   assign trig     = (dcnt_nxt >= DCNT_W'(DECIMATION));

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      li_in        = li_ff;
      dcnt_in      = dcnt_ff;
      ptr_in       = ptr_ff;
      delay_pct_in = delay_pct_ff;
      wet_pct_in   = wet_pct_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      x_in         = x_ff;
      rb_in        = rb_ff;
      sum_in       = sum_ff;
      ap_in_in     = ap_in_ff;
      lim_in       = lim_ff;
      eptr_in      = eptr_ff;
      mix_in       = mix_ff;
      q_in         = q_ff;
      out_in       = out_ff;
      mul_a        = rb_ff;
      mul_g        = AP_GAIN;
      mem_we       = 1'b0;
      mem_waddr    = ADDR_W'(LINE_OFFS[li_ff]) + ADDR_W'(eptr_ff);
      mem_wdata    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               x_in = req_sample_in;
               if (trig) begin
                  dcnt_in  = '0;
                  li_in    = '0;
                  sum_in   = '0;
                  state_in = ST_C_RD;
               end else begin
                  dcnt_in  = dcnt_nxt;
                  state_in = ST_MIX;
               end
            end
         end
         ST_C_RD: begin
            eptr_in  = eptr;
            lim_in   = LIM_W'(clip_pct(delay_pct_ff)) * LIM_W'(base_sel);
            state_in = ST_C_MUL;
         end
         ST_C_MUL: begin
            mul_a    = rdata_s;
            mul_g    = COMB_GAIN[li_ff[1:0]];
            sum_in   = sum_ff + (SW + 2)'(rdata_s);
            state_in = ST_C_WR;
         end
         ST_C_WR: begin
            mem_we    = 1'b1;
            mem_wdata = sat(EXT_W'(rnd15(prod_ff)) + EXT_W'(x_ff));
            ptr_in[li_ff] = ptr_wrap ? '0 : ptr_nxt;
            if (li_ff == LAST_COMB) begin
               ap_in_in = sat(avg_t);
               li_in    = FIRST_AP;
               state_in = ST_A_RD;
            end else begin
               li_in    = li_ff + LINE_IDX_W'(1);
               state_in = ST_C_RD;
            end
         end
         ST_A_RD: begin
            eptr_in  = eptr;
            lim_in   = LIM_W'(clip_pct(delay_pct_ff)) * LIM_W'(base_sel);
            mul_a    = ap_in_ff;
            state_in = ST_A_SUB;
         end
         ST_A_SUB: begin
            rb_in    = sat(EXT_W'(rdata_s) - EXT_W'(rnd15(prod_ff)));
            state_in = ST_A_MUL;
         end
         ST_A_MUL: begin
            state_in = ST_A_WR;
         end
         ST_A_WR: begin
            mem_we    = 1'b1;
            mem_wdata = sat(EXT_W'(rnd15(prod_ff)) + EXT_W'(ap_in_ff));
            ptr_in[li_ff] = ptr_wrap ? '0 : ptr_nxt;
            ap_in_in  = rb_ff;
            if (li_ff == LAST_AP) begin
               held_in  = rb_ff;
               state_in = ST_MIX;
            end else begin
               li_in    = li_ff + LINE_IDX_W'(1);
               state_in = ST_A_RD;
            end
         end
         ST_MIX: begin
            mix_in   = mix_t[U_W-1:0];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            q_in     = recip_p[RSH +: Q_W];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_in       = sat(out_t);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes; a delay write restarts every line
      if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY_PCT: begin
               delay_pct_in = csr_wdata;
               for (int i = 0; i < NUM_LINES; i++) begin
                  ptr_in[i] = '0;
               end
            end
            CSR_WET_PCT: begin
               wet_pct_in = csr_wdata;
            end
            default: begin
               wet_pct_in = wet_pct_ff;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         li_ff        <= '0;
         dcnt_ff      <= '0;
         delay_pct_ff <= DELAY_PCT_RST;
         wet_pct_ff   <= WET_PCT_RST;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LINES; i++) begin
            ptr_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         li_ff        <= li_in;
         dcnt_ff      <= dcnt_in;
         delay_pct_ff <= delay_pct_in;
         wet_pct_ff   <= wet_pct_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      prod_ff  <= prod_in;
      rb_ff    <= rb_in;
      sum_ff   <= sum_in;
      ap_in_ff <= ap_in_in;
      lim_ff   <= lim_in;
      eptr_ff  <= eptr_in;
      mix_ff   <= mix_in;
      q_ff     <= q_in;
      out_ff   <= out_in;
   end

`ifndef NO_ASSERTIONS
   // line RAM is written only by the clearing pass or a write-back step
   a_we_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_C_WR || state_ff == ST_A_WR))
      else $error("line RAM written outside a write-back step");

   // an accepted beat always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted beat left the sequencer idle");

   // decimation counter stays below the factor
   a_dcnt_range: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff < DCNT_W'(DECIMATION))
      else $error("decimation counter out of range");

   // a line is read only with its pointer inside the line
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_RD || state_ff == ST_A_RD) |-> (ptr_sel <= base_sel))
      else $error("line pointer beyond line length");

   // the output step waits while the previous result is still held
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_OUT))
      else $error("result overwritten before it was taken");
`endif

endmodule
